/* hdl/scwq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwq_pkg
// Shared types and constants for the counting semaphore with wait queue.
// ----------------------------------------------------------------------------
package scwq_pkg;

    localparam int THREAD_W   = 6;
    localparam int OPCODE_W   = 3;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 16;
    localparam int THREAD_IDS = 2 ** THREAD_W;
    localparam int COUNT_TOP  = 2 ** (COUNT_W - 1) - 1;

    localparam logic signed [COUNT_W-1:0] COUNT_FLOOR = {1'b1, {(COUNT_W-1){1'b0}}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_WAIT   = 3'd0,
        OP_SIGNAL = 3'd1,
        OP_TEST   = 3'd2,
        OP_CANCEL = 3'd3,
        OP_RESET  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED     = 3'd0,
        ST_BLOCKED     = 3'd1,
        ST_CANCELLED   = 3'd2,
        ST_WOKEN       = 3'd3,
        ST_UNAVAILABLE = 3'd4,
        ST_DONE        = 3'd5,
        ST_OVERFLOW    = 3'd6,
        ST_REJECTED    = 3'd7
    } status_t;

    typedef struct packed {
        status_t                    status;
        logic                       wake_valid;
        logic [THREAD_W-1:0]        wake_thread;
        logic                       has_waiters;
        logic signed [COUNT_W-1:0]  count_now;
    } result_t;

endpackage

/* hdl/scwq_link_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwq_link_mem
// Single-port-write, single-port-read link memory with registered read data.
// ----------------------------------------------------------------------------
module scwq_link_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rdata
);

    logic [AW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

/* hdl/scwq_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwq_core
// Semaphore count, queue ends and membership flags; computes one transaction
// from the registered request and the link words read at accept time.
// ----------------------------------------------------------------------------
module scwq_core
    import scwq_pkg::*;
#(
    parameter int MAX_THREADS = 64,
    parameter int COUNT_MAX   = 32767,
    parameter int DEPTH       = 64,
    parameter int IW          = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [OPCODE_W-1:0] op_in,
    input  logic [THREAD_W-1:0] tid_in,
    input  logic                commit,
    output logic [IW-1:0]       newer_raddr,
    output logic [IW-1:0]       older_raddr,
    input  logic [IW-1:0]       nw_data,
    input  logic [IW-1:0]       od_data,
    output logic                newer_we,
    output logic [IW-1:0]       newer_waddr,
    output logic [IW-1:0]       newer_wdata,
    output logic                older_we,
    output logic [IW-1:0]       older_waddr,
    output logic [IW-1:0]       older_wdata,
    output result_t             result
);

    localparam int LIMIT_INT = (COUNT_MAX < COUNT_TOP) ? COUNT_MAX : COUNT_TOP;
    localparam logic signed [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT_INT);

    logic [OPCODE_W-1:0]       op_reg;
    logic [THREAD_W-1:0]       tid_reg;
    logic signed [COUNT_W-1:0] count_reg, count_next;
    logic [IW-1:0]             newest_reg, newest_next;
    logic [IW-1:0]             oldest_reg, oldest_next;
    logic                      qne_reg, qne_next;
    logic [DEPTH-1:0]          inq_reg, inq_next;

    logic          tid_ok;
    logic [IW-1:0] t;
    logic          q_hit;
    logic          unlink_en;
    logic [IW-1:0] unlink_id;
    logic          is_new;
    logic          is_old;
    status_t       status;
    logic          wake_valid;
    logic [IW-1:0] wake_id;

    assign newer_raddr = (op_in == OP_SIGNAL) ? oldest_reg : tid_in[IW-1:0];
    assign older_raddr = tid_in[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_in;
            tid_reg <= tid_in;
        end
    end

    assign tid_ok = (int'(tid_reg) < MAX_THREADS);
    assign t      = tid_reg[IW-1:0];
    assign q_hit  = tid_ok && inq_reg[t];

    always_comb
    begin
        count_next  = count_reg;
        newest_next = newest_reg;
        oldest_next = oldest_reg;
        qne_next    = qne_reg;
        inq_next    = inq_reg;
        status      = ST_REJECTED;
        wake_valid  = 1'b0;
        wake_id     = '0;
        unlink_en   = 1'b0;
        unlink_id   = t;
        is_new      = 1'b0;
        is_old      = 1'b0;
        newer_we    = 1'b0;
        newer_waddr = newest_reg;
        newer_wdata = t;
        older_we    = 1'b0;
        older_waddr = t;
        older_wdata = newest_reg;

        case (op_t'(op_reg))
            OP_WAIT:
            begin
                if (!tid_ok || inq_reg[t] || count_reg == COUNT_FLOOR)
                begin
                    status = ST_REJECTED;
                end
                else
                begin
                    count_next = count_reg - 16'sd1;
                    if (count_reg <= 16'sd0)
                    begin
                        if (qne_reg)
                        begin
                            older_we = 1'b1;
                            newer_we = 1'b1;
                        end
                        else
                        begin
                            oldest_next = t;
                        end
                        newest_next = t;
                        inq_next[t] = 1'b1;
                        qne_next    = 1'b1;
                        status      = ST_BLOCKED;
                    end
                    else
                    begin
                        status = ST_GRANTED;
                    end
                end
            end
            OP_SIGNAL:
            begin
                if (count_reg >= COUNT_LIMIT)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + 16'sd1;
                    status     = ST_DONE;
                    if (count_reg < 16'sd0 && qne_reg)
                    begin
                        unlink_en  = 1'b1;
                        unlink_id  = oldest_reg;
                        wake_valid = 1'b1;
                        wake_id    = oldest_reg;
                    end
                end
            end
            OP_TEST:
            begin
                if (count_reg > 16'sd0)
                begin
                    count_next = count_reg - 16'sd1;
                    status     = ST_GRANTED;
                end
                else
                begin
                    status = ST_UNAVAILABLE;
                end
            end
            OP_CANCEL:
            begin
                if (q_hit)
                begin
                    unlink_en = 1'b1;
                    if (count_reg < COUNT_LIMIT)
                    begin
                        count_next = count_reg + 16'sd1;
                    end
                    status = ST_CANCELLED;
                end
                else
                begin
                    status = ST_WOKEN;
                end
            end
            OP_RESET:
            begin
                if (qne_reg)
                begin
                    status = ST_REJECTED;
                end
                else
                begin
                    count_next = '0;
                    status     = ST_DONE;
                end
            end
            default:
            begin
                status = ST_REJECTED;
            end
        endcase

        if (unlink_en)
        begin
            is_new = (unlink_id == newest_reg);
            is_old = (unlink_id == oldest_reg);
            if (is_new && is_old)
            begin
                qne_next = 1'b0;
            end
            else if (is_new)
            begin
                newest_next = od_data;
            end
            else if (is_old)
            begin
                oldest_next = nw_data;
            end
            else
            begin
                older_we    = 1'b1;
                older_waddr = nw_data;
                older_wdata = od_data;
                newer_we    = 1'b1;
                newer_waddr = od_data;
                newer_wdata = nw_data;
            end
            inq_next[unlink_id] = 1'b0;
        end

        if (!commit)
        begin
            newer_we = 1'b0;
            older_we = 1'b0;
        end
    end

    always_comb
    begin
        result.status      = status;
        result.wake_valid  = wake_valid;
        result.wake_thread = THREAD_W'(wake_id);
        result.has_waiters = qne_next;
        result.count_now   = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            newest_reg <= '0;
            oldest_reg <= '0;
            qne_reg    <= 1'b0;
            inq_reg    <= '0;
        end
        else if (commit)
        begin
            count_reg  <= count_next;
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
            qne_reg    <= qne_next;
            inq_reg    <= inq_next;
        end
    end

    // queue length tracks max(0, -count)
    a_queue_len: assert property (@(posedge clk) disable iff (!rst_n)
        int'($countones(inq_reg)) == (count_reg[COUNT_W-1] ? -int'(count_reg) : 0))
        else $error("queue membership does not match count");

    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        qne_reg == (inq_reg != '0))
        else $error("queue nonempty flag out of step with membership");

    a_ends_queued: assert property (@(posedge clk) disable iff (!rst_n)
        qne_reg |-> (inq_reg[newest_reg] && inq_reg[oldest_reg]))
        else $error("queue end is not a queued thread");

    a_woken_gone: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && wake_valid) |=> !inq_reg[$past(oldest_reg)])
        else $error("woken thread still queued");

endmodule

/* hdl/counting_semaphore_wait_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO queue of waiting thread IDs.
// ----------------------------------------------------------------------------
// Each request transaction runs in an accept cycle and an update cycle: in
// the accept cycle the link memories are read (registered read data), and in
// the update cycle the count, queue ends and links are updated and the result
// is loaded into the output register. A new request is taken while that
// result waits downstream; the update cycle stalls only while the output
// register is still full. No new request is taken until the update is done.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue
    import scwq_pkg::*;
#(
    parameter int MAX_THREADS = 64,
    parameter int COUNT_MAX   = 32767
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OPCODE_W-1:0]        opcode,
    input  logic [THREAD_W-1:0]        thread_id,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic                       wake_valid,
    output logic [THREAD_W-1:0]        wake_thread,
    output logic                       has_waiters,
    output logic signed [COUNT_W-1:0]  count_now
);

    localparam int DEPTH = (MAX_THREADS < THREAD_IDS) ? MAX_THREADS : THREAD_IDS;
    localparam int IW    = $clog2(DEPTH);

    logic    busy_reg, busy_next;
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;
    result_t result;
    logic    accept;
    logic    commit;

    logic [IW-1:0] newer_raddr, older_raddr;
    logic [IW-1:0] nw_data, od_data;
    logic          newer_we, older_we;
    logic [IW-1:0] newer_waddr, newer_wdata;
    logic [IW-1:0] older_waddr, older_wdata;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign commit   = busy_reg && (!out_valid_reg || out_ready);

    scwq_link_mem #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_newer_mem (
        .clk   (clk),
        .we    (newer_we),
        .waddr (newer_waddr),
        .wdata (newer_wdata),
        .re    (accept),
        .raddr (newer_raddr),
        .rdata (nw_data)
    );

    scwq_link_mem #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_older_mem (
        .clk   (clk),
        .we    (older_we),
        .waddr (older_waddr),
        .wdata (older_wdata),
        .re    (accept),
        .raddr (older_raddr),
        .rdata (od_data)
    );

    scwq_core #(
        .MAX_THREADS (MAX_THREADS),
        .COUNT_MAX   (COUNT_MAX),
        .DEPTH       (DEPTH),
        .IW          (IW)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op_in       (opcode),
        .tid_in      (thread_id),
        .commit      (commit),
        .newer_raddr (newer_raddr),
        .older_raddr (older_raddr),
        .nw_data     (nw_data),
        .od_data     (od_data),
        .newer_we    (newer_we),
        .newer_waddr (newer_waddr),
        .newer_wdata (newer_wdata),
        .older_we    (older_we),
        .older_waddr (older_waddr),
        .older_wdata (older_wdata),
        .result      (result)
    );

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (commit)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            res_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign wake_valid  = res_reg.wake_valid;
    assign wake_thread = res_reg.wake_thread;
    assign has_waiters = res_reg.has_waiters;
    assign count_now   = res_reg.count_now;

endmodule

/* verif/counting_semaphore_wait_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_tb
// Self-checking bench for the counting semaphore with FIFO wait queue.
// Requests go in over a valid/ready channel in random bursts. Each one is run
// through a behavioral semaphore with its own FIFO of waiters to build the
// expected response, and the responses are checked in order while the
// consumer stalls on a random pattern. The tests cover directed corners, full
// queue fill and drain, a random mix and a back-to-back count-up run.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_tb;
    import scwq_pkg::*;

    localparam int SEM_THREADS  = 64;
    localparam int SEM_MAX      = 32767;
    localparam int COUNT_CEIL   = (SEM_MAX < COUNT_TOP) ? SEM_MAX : COUNT_TOP;
    localparam int CLIMB_TOP    = 40;
    localparam int RANDOM_ITEMS = 110;
    localparam int CYCLE_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    localparam logic [OPCODE_W-1:0] OP_ILLEGAL_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_ILLEGAL_HI = 3'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [OPCODE_W-1:0]       opcode;
    logic [THREAD_W-1:0]       thread_id;
    logic                      out_valid;
    logic                      out_ready;
    logic [STATUS_W-1:0]       status;
    logic                      wake_valid;
    logic [THREAD_W-1:0]       wake_thread;
    logic                      has_waiters;
    logic signed [COUNT_W-1:0] count_now;

    // semaphore state as seen by the bench
    logic signed [COUNT_W-1:0] sem_count;
    logic [THREAD_W-1:0]       waiters[$];

    result_t pending_results[$];

    int  mismatch_count;
    int  cycle_count;
    int  burst_left;
    bit  idle_en;

    logic [31:0] stall_mask;
    int          stall_pos;

    counting_semaphore_wait_queue #(
        .MAX_THREADS (SEM_THREADS),
        .COUNT_MAX   (SEM_MAX)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .thread_id   (thread_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .wake_valid  (wake_valid),
        .wake_thread (wake_thread),
        .has_waiters (has_waiters),
        .count_now   (count_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic result_t apply_request(input logic [OPCODE_W-1:0] op,
                                              input logic [THREAD_W-1:0] tid);
        result_t r;
        int      c;
        int      slot;
        r    = '0;
        c    = sem_count;
        slot = -1;
        for (int i = 0; i < waiters.size(); i++)
        begin
            if (waiters[i] == tid)
                slot = i;
        end
        r.status = ST_REJECTED;
        case (op)
            OP_WAIT:
            begin
                if (slot < 0 && tid < SEM_THREADS && c > COUNT_FLOOR)
                begin
                    c = c - 1;
                    if (c < 0)
                    begin
                        waiters.push_back(tid);
                        r.status = ST_BLOCKED;
                    end
                    else
                        r.status = ST_GRANTED;
                end
            end
            OP_SIGNAL:
            begin
                if (c >= COUNT_CEIL)
                    r.status = ST_OVERFLOW;
                else
                begin
                    c = c + 1;
                    r.status = ST_DONE;
                    if (c <= 0 && waiters.size() != 0)
                    begin
                        r.wake_valid  = 1'b1;
                        r.wake_thread = waiters.pop_front();
                    end
                end
            end
            OP_TEST:
            begin
                if (c > 0)
                begin
                    c = c - 1;
                    r.status = ST_GRANTED;
                end
                else
                    r.status = ST_UNAVAILABLE;
            end
            OP_CANCEL:
            begin
                if (slot >= 0)
                begin
                    waiters.delete(slot);
                    if (c < COUNT_CEIL)
                        c = c + 1;
                    r.status = ST_CANCELLED;
                end
                else
                    r.status = ST_WOKEN;
            end
            OP_RESET:
            begin
                if (waiters.size() == 0)
                begin
                    c = 0;
                    r.status = ST_DONE;
                end
            end
            default: r.status = ST_REJECTED;
        endcase
        sem_count     = c[COUNT_W-1:0];
        r.has_waiters = (waiters.size() != 0);
        r.count_now   = sem_count;
        return r;
    endfunction

    task automatic issue_request(input logic [OPCODE_W-1:0] op,
                                 input logic [THREAD_W-1:0] tid);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (idle_en)
            begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        opcode    <= op;
        thread_id <= tid;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(apply_request(op, tid));
    endtask

    task automatic drain_results;
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string field, input int exp_val, input int act_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] %s mismatch: expected %0d, got %0d",
                     $realtime, field, exp_val, act_val);
    endtask

    task automatic check_response;
        result_t exp_r;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("[%0t] unexpected transaction: status %0d count %0d",
                         $realtime, status, count_now);
        end
        else
        begin
            exp_r = pending_results.pop_front();
            if (status !== exp_r.status)
                note_mismatch("status", exp_r.status, status);
            if (wake_valid !== exp_r.wake_valid)
                note_mismatch("wake_valid", exp_r.wake_valid, wake_valid);
            if (wake_thread !== exp_r.wake_thread)
                note_mismatch("wake_thread", exp_r.wake_thread, wake_thread);
            if (has_waiters !== exp_r.has_waiters)
                note_mismatch("has_waiters", exp_r.has_waiters, has_waiters);
            if (count_now !== exp_r.count_now)
                note_mismatch("count_now", exp_r.count_now, count_now);
        end
    endtask

    // consumer side: checks and stall pattern
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready)
            check_response();
        if (stall_pos == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_mask = '1;
                1: stall_mask = $urandom;
                2: stall_mask = $urandom & $urandom;
                default: stall_mask = 32'hCCCC_CCCC;
            endcase
        end
        out_ready <= idle_en ? stall_mask[stall_pos] : 1'b1;
        stall_pos = (stall_pos + 1) % 32;
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed_corners;
        issue_request(OP_TEST, 6'd0);
        issue_request(OP_SIGNAL, 6'd0);
        issue_request(OP_SIGNAL, 6'd0);
        issue_request(OP_TEST, 6'd0);
        issue_request(OP_WAIT, 6'd3);
        issue_request(OP_WAIT, 6'd5);
        issue_request(OP_WAIT, 6'd5);
        issue_request(OP_WAIT, 6'd0);
        issue_request(OP_WAIT, 6'd63);
        issue_request(OP_WAIT, 6'd42);
        issue_request(OP_CANCEL, 6'd0);
        issue_request(OP_CANCEL, 6'd42);
        issue_request(OP_CANCEL, 6'd5);
        issue_request(OP_CANCEL, 6'd9);
        issue_request(OP_RESET, 6'd0);
        issue_request(OP_TEST, 6'd0);
        issue_request(OP_SIGNAL, 6'd0);
        issue_request(OP_SIGNAL, 6'd0);
        issue_request(OP_RESET, 6'd21);
        for (int k = OP_ILLEGAL_LO; k <= OP_ILLEGAL_HI; k++)
            issue_request(OPCODE_W'(k), 6'd63);
        issue_request(OP_CANCEL, 6'd63);
        issue_request(OP_WAIT, 6'd63);
        issue_request(OP_CANCEL, 6'd63);
        drain_results();
    endtask

    task automatic test_queue_fill;
        logic [THREAD_W-1:0] order[SEM_THREADS];
        logic [THREAD_W-1:0] tmp;
        int                  j;
        for (int i = 0; i < SEM_THREADS; i++)
            order[i] = THREAD_W'(i);
        for (int i = SEM_THREADS - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < SEM_THREADS; i++)
        begin
            issue_request(OP_WAIT, order[i]);
            if ($urandom_range(0, 7) == 0)
                issue_request(OP_WAIT, order[$urandom_range(0, i)]);
        end
        while (waiters.size() != 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: issue_request(OP_SIGNAL, THREAD_W'($urandom));
                4, 5, 6, 7, 8:
                    issue_request(OP_CANCEL, waiters[$urandom_range(0, waiters.size() - 1)]);
                default: issue_request(OP_CANCEL, THREAD_W'($urandom));
            endcase
        end
        drain_results();
    endtask

    task automatic test_random_mix;
        int                  sel;
        logic [OPCODE_W-1:0] op;
        logic [THREAD_W-1:0] tid;
        repeat (RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            tid = THREAD_W'($urandom_range(0, SEM_THREADS - 1));
            if (sel < 35)
                op = OP_WAIT;
            else if (sel < 65)
                op = OP_SIGNAL;
            else if (sel < 77)
                op = OP_TEST;
            else if (sel < 92)
            begin
                op = OP_CANCEL;
                if (waiters.size() != 0 && $urandom_range(0, 3) != 0)
                    tid = waiters[$urandom_range(0, waiters.size() - 1)];
            end
            else if (sel < 97)
                op = OP_RESET;
            else
                op = OPCODE_W'($urandom_range(OP_ILLEGAL_LO, OP_ILLEGAL_HI));
            issue_request(op, tid);
        end
        drain_results();
    endtask

    task automatic test_count_climb;
        while (waiters.size() != 0)
            issue_request(OP_SIGNAL, 6'd0);
        issue_request(OP_RESET, 6'd0);
        drain_results();
        idle_en = 1'b0;
        while (sem_count < CLIMB_TOP)
            issue_request(OP_SIGNAL, THREAD_W'($urandom));
        issue_request(OP_SIGNAL, 6'd0);
        issue_request(OP_SIGNAL, 6'd63);
        issue_request(OP_TEST, 6'd0);
        issue_request(OP_SIGNAL, 6'd0);
        issue_request(OP_WAIT, 6'd17);
        issue_request(OP_CANCEL, 6'd17);
        issue_request(OP_RESET, 6'd0);
        drain_results();
        idle_en = 1'b1;
    endtask

    initial
    begin
        sem_count      = '0;
        mismatch_count = 0;
        burst_left     = 0;
        idle_en        = 1'b1;
        stall_mask     = '1;
        stall_pos      = 0;
        cycle_count    = 0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        opcode         <= OP_WAIT;
        thread_id      <= '0;
        out_ready      <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_queue_fill();
        test_random_mix();
        test_count_climb();
        test_random_mix();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
